// ----- rtl/adaptive_morse_decoder_top_defines.svh -----
// Assertion macros shared by the decoder's checking code.
// Each macro takes a label, a trigger condition and the expected condition.
`ifndef ADAPTIVE_MORSE_DECODER_TOP_DEFINES_SVH
`define ADAPTIVE_MORSE_DECODER_TOP_DEFINES_SVH

// The expected condition must hold in the same cycle as the trigger.
`define AMD_ASSERT_SAME(lbl, trig, expct) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (expct)) \
      else $error("decoder check failed in the same cycle");

// The expected condition must hold in the cycle after the trigger.
`define AMD_ASSERT_NEXT(lbl, trig, expct) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expct)) \
      else $error("decoder check failed in the following cycle");

`endif

// ----- rtl/amd_pkg.sv -----
package amd_pkg;

   // Number of counted intervals summed to measure the unit time.
   localparam int CALIB_INTERVALS = 16;
   localparam int CNT_W           = $clog2(CALIB_INTERVALS + 1);
   localparam int TICK_W          = 32;
   localparam int SUM_W           = 36;
   localparam int CODE_W          = 16;
   localparam int CHAR_W          = 8;
   localparam int DEB_W           = 16;
   localparam int MAX_RESULTS     = 3;
   localparam int COUNT_W         = 2;
   localparam int NUM_LETTERS     = 26;

   localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd1000;
   localparam logic [CHAR_W-1:0] LETTER_A       = 8'd65;
   localparam logic [CHAR_W-1:0] UNKNOWN_CHAR   = 8'd33;
   localparam logic [CHAR_W-1:0] WORD_END       = 8'd0;
   localparam logic [CHAR_W-1:0] SENTENCE_END   = 8'hFF;

   // Dot is 01 and dash is 011, appended from the right; letters A through Z.
   localparam logic [CODE_W-1:0] LETTER_CODES [NUM_LETTERS] = '{
      16'd11,  16'd213, 16'd429, 16'd53,  16'd1,   16'd173, 16'd109,
      16'd85,  16'd5,   16'd731, 16'd107, 16'd181, 16'd27,  16'd13,
      16'd219, 16'd365, 16'd875, 16'd45,  16'd21,  16'd3,   16'd43,
      16'd171, 16'd91,  16'd427, 16'd859, 16'd437
   };

   typedef struct packed {
      logic [TICK_W-1:0] ticks;
      logic              pressed;
   } item_type;

   typedef struct packed {
      logic [COUNT_W-1:0]                 count;
      logic [MAX_RESULTS-1:0][CHAR_W-1:0] chars;
   } rsp_set_type;

   typedef struct packed {
      logic fire;
      logic calibrating;
   } core_status_type;

   function automatic logic [CHAR_W-1:0] decode_letter(input logic [CODE_W-1:0] code);
      logic [CHAR_W-1:0] ch;
      ch = UNKNOWN_CHAR;
      for (int i = 0; i < NUM_LETTERS; i++) begin
         if (code == LETTER_CODES[i]) begin
            ch = LETTER_A + CHAR_W'(i);
         end
      end
      return ch;
   endfunction

endpackage

// ----- rtl/amd_core.sv -----
module amd_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [amd_pkg::DEB_W-1:0]         debounce,
   input  logic                              item_valid,
   input  amd_pkg::item_type                 item,
   input  logic                              buf_free,
   output amd_pkg::rsp_set_type              set,
   output amd_pkg::core_status_type          status
);

   logic [amd_pkg::TICK_W-1:0] pending_ff, pending_in;
   logic [amd_pkg::TICK_W-1:0] unit_ff, unit_in;
   logic                       calibrating_ff, calibrating_in;
   logic [amd_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [amd_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [amd_pkg::CODE_W-1:0] symbol_ff, symbol_in;

   logic [amd_pkg::TICK_W:0]   merged;
   logic [amd_pkg::TICK_W-1:0] total;
   logic                       counted;
   logic [amd_pkg::SUM_W-1:0]  sum_next;
   logic [amd_pkg::TICK_W:0]   unit2;
   logic [amd_pkg::TICK_W+2:0] unit5;
   logic [amd_pkg::TICK_W+3:0] unit10;
   logic                       over2, over5, over10, under2;
   logic                       fire;

   always_comb begin
      merged  = {1'b0, pending_ff} + {1'b0, item.ticks};
      total   = merged[amd_pkg::TICK_W] ? '1 : merged[amd_pkg::TICK_W-1:0];
      counted = total > {{(amd_pkg::TICK_W - amd_pkg::DEB_W){1'b0}}, debounce};

      unit2  = {unit_ff, 1'b0};
      unit5  = {1'b0, unit_ff, 2'b00} + {3'b000, unit_ff};
      unit10 = {unit5, 1'b0};
      under2 = {1'b0, total} < unit2;
      over2  = {1'b0, total} > unit2;
      over5  = {3'b000, total} > unit5;
      over10 = {4'b0000, total} > unit10;

      sum_next = (count_ff != '0) ? sum_ff + {4'b0000, total} : sum_ff;

      // Results only come from a counted release after calibration; the
      // thresholds nest, so the count is the number of crossed ones.
      set.chars = {amd_pkg::SENTENCE_END, amd_pkg::WORD_END,
                   amd_pkg::decode_letter(symbol_ff)};
      set.count = '0;
      if (counted && !calibrating_ff && !item.pressed) begin
         set.count = amd_pkg::COUNT_W'({1'b0, over2} + {1'b0, over5} + {1'b0, over10});
      end

      fire = item_valid && (buf_free || set.count == '0);
      status.fire        = fire;
      status.calibrating = calibrating_ff;

      pending_in     = pending_ff;
      unit_in        = unit_ff;
      calibrating_in = calibrating_ff;
      count_in       = count_ff;
      sum_in         = sum_ff;
      symbol_in      = symbol_ff;
      if (fire) begin
         if (!counted) begin
            pending_in = total;
         end else begin
            pending_in = '0;
            if (calibrating_ff) begin
               sum_in   = sum_next;
               count_in = amd_pkg::CNT_W'(count_ff + 1'b1);
               if (count_ff >= amd_pkg::CNT_W'(amd_pkg::CALIB_INTERVALS)) begin
                  unit_in        = amd_pkg::TICK_W'(sum_next / amd_pkg::CALIB_INTERVALS);
                  calibrating_in = 1'b0;
               end
            end else if (item.pressed) begin
               if (under2) begin
                  symbol_in = {symbol_ff[amd_pkg::CODE_W-3:0], 2'b01};
               end else if (over2) begin
                  symbol_in = {symbol_ff[amd_pkg::CODE_W-4:0], 3'b011};
               end
            end else if (over2) begin
               symbol_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff     <= '0;
         unit_ff        <= '0;
         calibrating_ff <= 1'b1;
         count_ff       <= '0;
         sum_ff         <= '0;
         symbol_ff      <= '0;
      end else begin
         pending_ff     <= pending_in;
         unit_ff        <= unit_in;
         calibrating_ff <= calibrating_in;
         count_ff       <= count_in;
         sum_ff         <= sum_in;
         symbol_ff      <= symbol_in;
      end
   end

endmodule

// ----- rtl/amd_outbuf.sv -----
module amd_outbuf (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  amd_pkg::rsp_set_type         set,
   output logic                         free,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [amd_pkg::CHAR_W-1:0]   rsp_tdata,
   output logic                         rsp_tlast
);

   logic [amd_pkg::COUNT_W-1:0]                 rem_ff, rem_in;
   logic [amd_pkg::MAX_RESULTS-1:0][amd_pkg::CHAR_W-1:0] chars_ff, chars_in;
   logic                                        take;

   always_comb begin
      rsp_tvalid = rem_ff != '0;
      rsp_tdata  = chars_ff[0];
      rsp_tlast  = rem_ff == amd_pkg::COUNT_W'(1);
      take       = rsp_tvalid && rsp_tready;
      free       = (rem_ff == '0) || (rsp_tlast && rsp_tready);

      rem_in   = rem_ff;
      chars_in = chars_ff;
      if (load && set.count != '0) begin
         rem_in   = set.count;
         chars_in = set.chars;
      end else if (take) begin
         rem_in   = rem_ff - 1'b1;
         chars_in = {amd_pkg::CHAR_W'(0), chars_ff[amd_pkg::MAX_RESULTS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
      chars_ff <= chars_in;
   end

endmodule

// ----- rtl/adaptive_morse_decoder_top.sv -----
// Adaptive-timing Morse decoder.
// Requests arrive on the req_ stream: each one carries the length in timer
// ticks of one key interval (tdata) and whether the key was pressed (tuser).
// Decoded characters leave on the rsp_ stream, one byte per transfer on the
// output, with tlast set on the final character caused by one input interval.
// The debounce threshold is written through the csr_ channel, which is always
// ready; write it only while the decoder is idle.
// Flow: a taken request is held in the input register and decoded from it;
// its characters are loaded into the output buffer register and offered from
// there. Requests that produce no character flow at one per cycle. An
// interval that produces n characters holds the result buffer until all n
// are taken, so the sustained rate is set by the output buffer draining at
// one character per cycle while the receiver is ready.
// Reset clears the pending merge, restarts calibration (the first counted
// interval is dropped and the next sixteen measure the unit time), clears the
// letter register and sets the debounce threshold to 1000 ticks.
// When the receiver stalls, the buffered characters hold. Requests that give
// no character still pass at one per cycle; the first one that gives
// characters waits in the input register, and then req_tready drops.
`include "adaptive_morse_decoder_top_defines.svh"

module adaptive_morse_decoder_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [amd_pkg::TICK_W-1:0]        req_tdata,   // [31:0] interval_ticks
   input  logic [0:0]                        req_tuser,   // [0] was_pressed
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [amd_pkg::CHAR_W-1:0]        rsp_tdata,   // [7:0] char_code
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [amd_pkg::DEB_W-1:0]         csr_data     // [15:0] debounce_ticks
);

   // Input register: holds one request until the decoder can process it.
   logic                        in_valid_ff, in_valid_in;
   amd_pkg::item_type           item_ff, item_in;
   logic [amd_pkg::DEB_W-1:0]   debounce_ff, debounce_in;

   amd_pkg::rsp_set_type        core_set;
   amd_pkg::core_status_type    core_status;
   logic                        buf_free;

   always_comb begin
      csr_ready   = 1'b1;
      debounce_in = (csr_valid && csr_ready) ? csr_data : debounce_ff;

      // The register frees up in the same cycle its request is decoded.
      req_tready  = !in_valid_ff || core_status.fire;
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in   = 1'b1;
         item_in.ticks   = req_tdata;
         item_in.pressed = req_tuser[0];
      end else if (core_status.fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         debounce_ff <= amd_pkg::DEBOUNCE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         debounce_ff <= debounce_in;
      end
      item_ff <= item_in;
   end

   amd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .debounce   (debounce_ff),
      .item_valid (in_valid_ff),
      .item       (item_ff),
      .buf_free   (buf_free),
      .set        (core_set),
      .status     (core_status)
   );

   amd_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (core_status.fire),
      .set        (core_set),
      .free       (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Characters of one interval leave without gaps between them.
   `AMD_ASSERT_NEXT(a_burst_contiguous, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid)
   // Calibration intervals never produce characters.
   `AMD_ASSERT_SAME(a_calib_silent, core_status.fire && core_status.calibrating, core_set.count == '0)
   // The decoder never overwrites a character the receiver has not taken.
   `AMD_ASSERT_SAME(a_no_overwrite, rsp_tvalid && !rsp_tready, !(core_status.fire && core_set.count != '0))

endmodule

// ----- tb/morse_char_checker.sv -----
`timescale 1ns / 1ps

// Watches the three channels of the decoder, keeps its own copy of the decoder state,
// and checks every character against the oldest predicted one.
module morse_char_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [amd_pkg::TICK_W-1:0]   req_tdata,   // [31:0] interval_ticks
   input  logic [0:0]                   req_tuser,   // [0] was_pressed
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [amd_pkg::CHAR_W-1:0]   rsp_tdata,   // [7:0] char_code
   input  logic                         rsp_tlast,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [amd_pkg::DEB_W-1:0]    csr_data,    // [15:0] debounce_ticks
   output int                           fail_count,
   output int                           open_count,
   output int                           chars_checked
);

   localparam logic [7:0] GLYPH_A        = 8'd65;
   localparam logic [7:0] GLYPH_UNKNOWN  = 8'd33;
   localparam logic [7:0] GLYPH_WORD     = 8'd0;
   localparam logic [7:0] GLYPH_SENTENCE = 8'hFF;

   // Dot appends 01 and dash appends 011; entries run from A to Z.
   localparam logic [15:0] MORSE_PATTERNS [26] = '{
      16'd11,  16'd213, 16'd429, 16'd53,  16'd1,   16'd173, 16'd109, 16'd85,  16'd5,
      16'd731, 16'd107, 16'd181, 16'd27,  16'd13,  16'd219, 16'd365, 16'd875, 16'd45,
      16'd21,  16'd3,   16'd43,  16'd171, 16'd91,  16'd427, 16'd859, 16'd437
   };

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } glyph_type;

   glyph_type   expected_glyphs [$];
   glyph_type   oldest;

   logic [15:0] debounce;
   logic [31:0] pending;
   logic [31:0] unit_len;
   logic        calibrating;
   logic [4:0]  calib_count;
   logic [35:0] calib_sum;
   logic [15:0] symbol;
   int          errors;
   int          checked;

   function automatic logic [7:0] glyph_of(input logic [15:0] pattern);
      int idx;
      idx = 0;
      while (idx < 26 && MORSE_PATTERNS[idx] != pattern) idx++;
      return (idx < 26) ? GLYPH_A + 8'(idx) : GLYPH_UNKNOWN;
   endfunction

   task automatic decode_interval(input logic [31:0] ticks, input logic pressed);
      logic [32:0] merged;
      logic [63:0] span;
      logic [63:0] unit_w;
      logic [7:0]  glyphs [3];
      glyph_type   g;
      int          n;
      merged = {1'b0, pending} + {1'b0, ticks};
      span   = merged[32] ? 64'hFFFF_FFFF : {32'd0, merged[31:0]};
      if (span <= {48'd0, debounce}) begin
         pending = span[31:0];
         return;
      end
      pending = '0;
      if (calibrating) begin
         // The very first counted interval only opens the measurement.
         if (calib_count != 0) calib_sum = calib_sum + span[35:0];
         if (calib_count >= 5'(amd_pkg::CALIB_INTERVALS)) begin
            unit_len    = 32'(calib_sum / amd_pkg::CALIB_INTERVALS);
            calibrating = 1'b0;
         end
         calib_count = calib_count + 5'd1;
         return;
      end
      unit_w = {32'd0, unit_len};
      if (pressed) begin
         if (span < 2 * unit_w) symbol = {symbol[13:0], 2'b01};
         else if (span > 2 * unit_w) symbol = {symbol[12:0], 3'b011};
         return;
      end
      n = 0;
      if (span > 2 * unit_w) begin
         glyphs[n] = glyph_of(symbol);
         n++;
         symbol = '0;
      end
      if (span > 5 * unit_w) begin
         glyphs[n] = GLYPH_WORD;
         n++;
      end
      if (span > 10 * unit_w) begin
         glyphs[n] = GLYPH_SENTENCE;
         n++;
      end
      for (int k = 0; k < n; k++) begin
         g.code = glyphs[k];
         g.last = (k == n - 1);
         expected_glyphs.push_back(g);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         debounce    = amd_pkg::DEBOUNCE_RESET;
         pending     = '0;
         unit_len    = '0;
         calibrating = 1'b1;
         calib_count = '0;
         calib_sum   = '0;
         symbol      = '0;
         expected_glyphs.delete();
      end else begin
         if (csr_valid && csr_ready) debounce = csr_data;
         if (req_tvalid && req_tready) decode_interval(req_tdata, req_tuser[0]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_glyphs.size() == 0) begin
               errors++;
               $error("char_code %0d (last %0b) arrived with nothing expected",
                      rsp_tdata, rsp_tlast);
            end else begin
               oldest = expected_glyphs.pop_front();
               checked++;
               if (rsp_tdata !== oldest.code) begin
                  errors++;
                  $error("char_code mismatch: expected %0d, got %0d", oldest.code, rsp_tdata);
               end
               if (rsp_tlast !== oldest.last) begin
                  errors++;
                  $error("last mismatch: expected %0b, got %0b", oldest.last, rsp_tlast);
               end
            end
         end
      end
      fail_count    <= errors;
      open_count    <= expected_glyphs.size();
      chars_checked <= checked;
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

// Top of the decoder testbench. It creates the stimulus: key intervals on the
// request stream, debounce writes on the csr channel and back-pressure on the
// result stream. All prediction and comparison lives in morse_char_checker.
module testbench;

   // Calibration below is built so that the measured unit comes out at exactly
   // this many ticks, which lets the stimulus aim at the decision boundaries.
   localparam int UNIT_TICKS     = 3000;
   localparam int GAP_MAX        = 12;
   // Extra wait after the last character is taken, enough for a request that
   // produces no character to leave the input register and the decoder.
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEM_TARGET    = 280;
   localparam int PHASE_ITEMS    = 35;

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [amd_pkg::TICK_W-1:0]   req_tdata;   // [31:0] interval_ticks
   logic [0:0]                   req_tuser;   // [0] was_pressed
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [amd_pkg::CHAR_W-1:0]   rsp_tdata;   // [7:0] char_code
   logic                         rsp_tlast;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [amd_pkg::DEB_W-1:0]    csr_data;    // [15:0] debounce_ticks

   int                           fail_count;
   int                           open_count;
   int                           chars_checked;

   // Sender bookkeeping: requests accepted so far, debounce settings applied,
   // and the threshold currently in force so intervals can be shaped around it.
   int                           sent;
   int                           settings_used;
   int                           quiet_cycles;
   bit                           sender_burst;
   logic [amd_pkg::DEB_W-1:0]    debounce_now;

   adaptive_morse_decoder_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   morse_char_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .open_count    (open_count),
      .chars_checked (chars_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Random value in [lo, hi]; collapses to lo when the range is empty.
   function automatic logic [31:0] pick(input int unsigned lo, input int unsigned hi);
      if (hi <= lo) return lo;
      return $urandom_range(hi, lo);
   endfunction

   // Offers one request after a random gap and returns at the edge where it is
   // taken. tvalid stays high on return, so back-to-back requests need no gap.
   task automatic send_interval(input logic [31:0] ticks, input logic pressed);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(GAP_MAX, 0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ticks;
      req_tuser  <= pressed;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // Sends an interval that is meant to count. Now and then it is split in two
   // so that the first piece is swallowed by the debounce merge and the second
   // completes it; the merged length equals the intended one.
   task automatic send_counted(input logic [31:0] ticks, input logic pressed);
      logic [31:0] piece;
      if (debounce_now != 0 && $urandom_range(5, 0) == 0) begin
         piece = pick(0, 32'(debounce_now));
         send_interval(piece, 1'($urandom_range(1, 0)));
         send_interval(ticks - piece, pressed);
      end else begin
         send_interval(ticks, pressed);
      end
   endtask

   // One well-formed letter: dots and dashes separated by short releases, then
   // a long release whose length decides whether a word or sentence end follows.
   // Patterns of up to four symbols are mostly real letters; five or six give
   // unknown patterns, and six dashes overflow the 16-bit letter register.
   task automatic send_letter();
      int symbols;
      symbols = ($urandom_range(9, 0) < 8) ? $urandom_range(4, 1) : $urandom_range(6, 5);
      for (int s = 0; s < symbols; s++) begin
         if ($urandom_range(1, 0) == 1) begin
            send_counted(pick(2 * UNIT_TICKS + 1, 4 * UNIT_TICKS), 1'b1);
         end else begin
            send_counted(pick(debounce_now + 1, 2 * UNIT_TICKS - 1), 1'b1);
         end
         // A press of exactly two units must leave the letter untouched.
         if ($urandom_range(15, 0) == 0) send_counted(2 * UNIT_TICKS, 1'b1);
         if (s != symbols - 1) send_counted(pick(debounce_now + 1, 2 * UNIT_TICKS), 1'b0);
      end
      case ($urandom_range(5, 0))
         0, 1: send_counted(pick(2 * UNIT_TICKS + 1, 5 * UNIT_TICKS), 1'b0);
         2:    send_counted(pick(5 * UNIT_TICKS + 1, 10 * UNIT_TICKS), 1'b0);
         3:    send_counted(pick(10 * UNIT_TICKS + 1, 40 * UNIT_TICKS), 1'b0);
         4:    send_counted(($urandom_range(1, 0) == 1) ? 5 * UNIT_TICKS : 10 * UNIT_TICKS, 1'b0);
         default: begin
            // A release of exactly two units ends nothing; the next one does.
            send_counted(2 * UNIT_TICKS, 1'b0);
            send_counted(2 * UNIT_TICKS + 1, 1'b0);
         end
      endcase
   endtask

   // Unshaped interval: the full 32-bit range at random widths, plus the two
   // extremes, with a random key level.
   task automatic send_noise();
      logic [31:0] ticks;
      case ($urandom_range(7, 0))
         0:       ticks = '0;
         1:       ticks = 32'hFFFF_FFFF;
         default: ticks = $urandom >> $urandom_range(31, 0);
      endcase
      send_interval(ticks, 1'($urandom_range(1, 0)));
   endtask

   // Stops offering requests and waits until every predicted character has
   // been taken, then lets the pipeline settle so that a request without any
   // character is surely finished too. The watchdog bounds this wait.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_debounce(input logic [amd_pkg::DEB_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      debounce_now  = value;
      settings_used++;
   endtask

   // Result side: before each character it draws a random stall, bounded by GAP_MAX,
   // except in stretches of full-speed draining that are chosen every 32 characters.
   initial begin : result_sink
      int stall;
      int served;
      bit burst;
      served = 0;
      burst  = 1'b0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (served % 32 == 0) burst = ($urandom_range(2, 0) == 0);
         stall = burst ? 0 : $urandom_range(GAP_MAX, 0);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         served++;
      end
   end

   // Watchdog: a stuck handshake anywhere ends the run as a failure.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int          phase;
      int          phase_end;
      logic [31:0] offset;
      logic [amd_pkg::DEB_W-1:0] next_debounce;
      sent          = 0;
      settings_used = 0;
      sender_burst  = 1'b0;
      debounce_now  = amd_pkg::DEBOUNCE_RESET;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset threshold of 1000 ticks.
      // A short interval is held back by the debounce merge, and the huge one
      // after it saturates the merged length; that counted interval is the one
      // calibration throws away.
      send_interval(32'd500, 1'b0);
      send_interval(32'hFFFF_FFFF, 1'b1);
      // Sixteen calibration intervals around the unit, in pairs that cancel,
      // with one of them assembled from a glitch and its remainder.
      for (int i = 0; i < 7; i++) begin
         offset = pick(0, 1900);
         send_interval(UNIT_TICKS + offset, 1'b1);
         send_interval(UNIT_TICKS - offset, 1'b0);
      end
      send_interval(32'd400, 1'b0);
      send_interval(UNIT_TICKS - 400, 1'b1);
      send_interval(UNIT_TICKS, 1'b0);
      // Unit is now 3000 ticks. A press of exactly two units does nothing, a
      // dot and a dash make an A, a short release stays silent, and releases
      // just past two units, at exactly five, at exactly ten and at the top of
      // the range give one, one, two and three characters.
      send_interval(2 * UNIT_TICKS, 1'b1);
      send_interval(UNIT_TICKS, 1'b1);
      send_interval(2 * UNIT_TICKS, 1'b0);
      send_interval(2 * UNIT_TICKS + 1, 1'b1);
      send_interval(2 * UNIT_TICKS + 1, 1'b0);
      send_interval(5 * UNIT_TICKS, 1'b0);
      send_interval(10 * UNIT_TICKS, 1'b0);
      send_interval(32'hFFFF_FFFF, 1'b0);
      // The sender holds off here until every character has come back.
      drain();

      // Random part: one debounce setting per phase, extremes first. Settings under
      // two units minus one tick allow real letters; the others get noise only,
      // which mostly exercises merging and saturation.
      phase = 0;
      while (sent < ITEM_TARGET) begin
         case (phase)
            0:       next_debounce = '0;
            1:       next_debounce = '1;
            2:       next_debounce = amd_pkg::DEBOUNCE_RESET;
            4:       next_debounce = amd_pkg::DEB_W'($urandom_range(65535, 0));
            default: next_debounce = amd_pkg::DEB_W'($urandom_range(2500, 0));
         endcase
         write_debounce(next_debounce);
         sender_burst = ($urandom_range(3, 0) == 0);
         if (debounce_now < 2 * UNIT_TICKS - 1) begin
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end) begin
               if ($urandom_range(4, 0) != 0) send_letter();
               else send_noise();
            end
         end else begin
            phase_end = sent + PHASE_ITEMS / 2;
            while (sent < phase_end) send_noise();
         end
         drain();
         phase++;
      end

      $display("Covered %0d requests under %0d debounce settings, 0 and 65535 included.",
               sent, settings_used);
      $display("Compared %0d decoded characters with their predictions.", chars_checked);
      if (fail_count == 0 && open_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/amd_pkg.sv
rtl/amd_core.sv
rtl/amd_outbuf.sv
rtl/adaptive_morse_decoder_top.sv
tb/morse_char_checker.sv
tb/testbench.sv
